[rtl/descriptor_chain_free_list_core_macros.svh]
// Assertion macros for the descriptor chain free list core.
// Every macro samples on clock and is switched off while reset is high.
`ifndef DESCRIPTOR_CHAIN_FREE_LIST_CORE_MACROS_SVH
`define DESCRIPTOR_CHAIN_FREE_LIST_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCFL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCFL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The expression must never be true.
`define DCFL_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

[rtl/dcfl_pkg.sv]
// Shared constants, codes and types of the descriptor chain free list core.
// No dependencies; every other file of the block but the assertion macro header imports this package.
package dcfl_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_BAD_COUNT = 2'd2;

   typedef struct packed {
      logic             cmd;
      logic [CNT_W-1:0] entry_count;
      logic [IDX_W-1:0] release_head;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] chain_head;
      logic [IDX_W-1:0] chain_tail;
      logic [CNT_W-1:0] free_left;
   } rsp_payload_type;

   // Link store access: one read and one write per cycle.
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] wr_link;
      logic             wr_more;
   } link_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0] link;
      logic             more;
   } link_rsp_type;

   // Chain record store access, keyed by chain head.
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [CNT_W-1:0] wr_count;
      logic [IDX_W-1:0] wr_tail;
   } record_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] tail;
   } record_rsp_type;

endpackage

[rtl/dcfl_if.sv]
// Valid/ready channel interfaces of the descriptor chain free list core.
// Depends on dcfl_pkg for the payload types.
interface dcfl_req_if
   import dcfl_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dcfl_rsp_if
   import dcfl_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/descriptor_chain_free_list_core.sv]
// Top level of the descriptor chain free list core: sequencer, link store,
// chain record store and result register. Depends on dcfl_pkg and dcfl_if.
//
//   Channel    Direction  Handshake        Carries
//   req_chan   in         valid / ready    cmd, entry_count, release_head
//   rsp_chan   out        valid / ready    status, chain_head, chain_tail, free_left
//
// An allocate reads the link store once per descriptor between acceptance and
// hand-over, a free reads the chain record and splices the chain back, and a
// rejected allocate goes straight to hand-over. Commands run one at a time; a
// new one is accepted while the previous result waits in the output register.
// Reset is synchronous and immediate: the free list returns to its initial ring.
module descriptor_chain_free_list_core
   import dcfl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dcfl_req_if.sink  req_chan,
   dcfl_rsp_if.source rsp_chan
);

   link_cmd_type    link_cmd;
   link_rsp_type    link_rsp;
   record_cmd_type  rec_cmd;
   record_rsp_type  rec_rsp;
   logic            res_valid;
   rsp_payload_type res_data;
   logic            res_take;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;

   dcfl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_data  (req_chan.payload),
      .req_ready (req_chan.ready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (res_take),
      .link_cmd  (link_cmd),
      .link_rsp  (link_rsp),
      .rec_cmd   (rec_cmd),
      .rec_rsp   (rec_rsp)
   );

   dcfl_link_store u_link_store (
      .clock (clock),
      .reset (reset),
      .cmd   (link_cmd),
      .rsp   (link_rsp)
   );

   dcfl_record_store u_record_store (
      .clock (clock),
      .cmd   (rec_cmd),
      .rsp   (rec_rsp)
   );

   // The output register takes a finished result whenever it is empty or
   // its current transaction completes in the same cycle.
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in  = res_take ? res_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

[rtl/dcfl_link_store.sv]
// Link store: next link and more-flag of every descriptor, registered read.
// Depends on dcfl_pkg. Entries never written read as their reset values.
module dcfl_link_store
   import dcfl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  link_cmd_type cmd,
   output link_rsp_type rsp
);

   logic [IDX_W:0]       mem [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff;
   logic [IDX_W:0]       rd_word_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_addr_ff;
   logic                 rd_last;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= {cmd.wr_link, cmd.wr_more};
      end
      if (cmd.rd_en) begin
         rd_word_ff <= mem[cmd.rd_addr];
         rd_vld_ff  <= valid_ff[cmd.rd_addr];
         rd_addr_ff <= cmd.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   // An unwritten entry holds the reset ring: link to the next index, and
   // the more-flag is set everywhere but on the last descriptor.
   assign rd_last = (rd_addr_ff == IDX_W'(QUEUE_DEPTH - 1));

   always_comb begin
      if (rd_vld_ff) begin
         rsp.link = rd_word_ff[IDX_W:1];
         rsp.more = rd_word_ff[0];
      end else begin
         rsp.link = rd_last ? '0 : rd_addr_ff + 1'b1;
         rsp.more = !rd_last;
      end
   end

endmodule

[rtl/dcfl_record_store.sv]
// Chain record store: count and tail of each allocated chain by its head.
// Depends on dcfl_pkg. Contents are undefined until written.
module dcfl_record_store
   import dcfl_pkg::*;
(
   input  logic           clock,
   input  record_cmd_type cmd,
   output record_rsp_type rsp
);

   logic [CNT_W+IDX_W-1:0] mem [QUEUE_DEPTH];
   logic [CNT_W+IDX_W-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= {cmd.wr_count, cmd.wr_tail};
      end
      if (cmd.rd_en) begin
         rd_word_ff <= mem[cmd.rd_addr];
      end
   end

   assign rsp.count = rd_word_ff[CNT_W+IDX_W-1:IDX_W];
   assign rsp.tail  = rd_word_ff[IDX_W-1:0];

endmodule

[rtl/dcfl_engine.sv]
// Command sequencer: walks the link store for allocate, splices chains back
// for free, and keeps the free head and free count. Depends on dcfl_pkg.
`include "descriptor_chain_free_list_core_macros.svh"

module dcfl_engine
   import dcfl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_data,
   output logic            req_ready,
   output logic            res_valid,
   output rsp_payload_type res_data,
   input  logic            res_take,
   output link_cmd_type    link_cmd,
   input  link_rsp_type    link_rsp,
   output record_cmd_type  rec_cmd,
   input  record_rsp_type  rec_rsp
);

   typedef enum logic [1:0] {IDLE, WALK, FREE_RD, DONE} state_type;

   state_type        state_ff,      state_in;
   logic [IDX_W-1:0] free_head_ff,  free_head_in;
   logic [CNT_W-1:0] free_total_ff, free_total_in;
   logic [IDX_W-1:0] cur_ff,        cur_in;
   logic [IDX_W-1:0] head_ff,       head_in;
   logic [CNT_W-1:0] remain_ff,     remain_in;
   logic [CNT_W-1:0] count_ff,      count_in;
   rsp_payload_type  result_ff,     result_in;

   logic             alloc_go;
   logic [CNT_W:0]   sum_total;
   logic [CNT_W-1:0] left_after;

   assign sum_total = {1'b0, free_total_ff} + {1'b0, rec_rsp.count};
   assign left_after = free_total_ff - count_ff;

   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      free_total_in = free_total_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      remain_in     = remain_ff;
      count_in      = count_ff;
      result_in     = result_ff;
      link_cmd      = '0;
      rec_cmd       = '0;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      alloc_go      = 1'b0;

      case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.cmd == CMD_FREE) begin
                  rec_cmd.rd_en   = 1'b1;
                  rec_cmd.rd_addr = req_data.release_head;
                  head_in         = req_data.release_head;
                  state_in        = FREE_RD;
               end else if (req_data.entry_count == '0 ||
                            req_data.entry_count > CNT_W'(QUEUE_DEPTH)) begin
                  result_in = '{STATUS_BAD_COUNT, '0, '0, free_total_ff};
                  state_in  = DONE;
               end else if (req_data.entry_count > free_total_ff) begin
                  result_in = '{STATUS_SHORT, '0, '0, free_total_ff};
                  state_in  = DONE;
               end else begin
                  alloc_go         = 1'b1;
                  link_cmd.rd_en   = 1'b1;
                  link_cmd.rd_addr = free_head_ff;
                  cur_in           = free_head_ff;
                  head_in          = free_head_ff;
                  remain_in        = req_data.entry_count;
                  count_in         = req_data.entry_count;
                  state_in         = WALK;
               end
            end
         end
         WALK: begin
            if (remain_ff == CNT_W'(1)) begin
               // Last descriptor of the chain: close it and record the chain.
               link_cmd.wr_en   = 1'b1;
               link_cmd.wr_addr = cur_ff;
               link_cmd.wr_link = link_rsp.link;
               link_cmd.wr_more = 1'b0;
               rec_cmd.wr_en    = 1'b1;
               rec_cmd.wr_addr  = head_ff;
               rec_cmd.wr_count = count_ff;
               rec_cmd.wr_tail  = cur_ff;
               free_head_in     = link_rsp.link;
               free_total_in    = left_after;
               result_in        = '{STATUS_OK, head_ff, cur_ff, left_after};
               state_in         = DONE;
            end else begin
               link_cmd.rd_en   = 1'b1;
               link_cmd.rd_addr = link_rsp.link;
               cur_in           = link_rsp.link;
               remain_in        = remain_ff - 1'b1;
            end
         end
         FREE_RD: begin
            // With an empty list the old head is stale, so the tail keeps
            // its link and flag.
            if (free_total_ff != '0) begin
               link_cmd.wr_en   = 1'b1;
               link_cmd.wr_addr = rec_rsp.tail;
               link_cmd.wr_link = free_head_ff;
               link_cmd.wr_more = 1'b1;
            end
            if (sum_total > (CNT_W+1)'(QUEUE_DEPTH)) begin
               free_total_in = CNT_W'(QUEUE_DEPTH);
            end else begin
               free_total_in = sum_total[CNT_W-1:0];
            end
            free_head_in = head_ff;
            result_in    = '{STATUS_OK, '0, '0, free_total_in};
            state_in     = DONE;
         end
         DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   assign res_data = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         free_head_ff  <= '0;
         free_total_ff <= CNT_W'(QUEUE_DEPTH);
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_total_ff <= free_total_in;
      end
      cur_ff    <= cur_in;
      head_ff   <= head_in;
      remain_ff <= remain_in;
      count_ff  <= count_in;
      result_ff <= result_in;
   end

   `DCFL_ASSERT_NEVER(a_total_in_range, free_total_ff > CNT_W'(QUEUE_DEPTH), "free count above depth")
   `DCFL_ASSERT_IMPL(a_walk_remaining, state_ff == WALK, remain_ff != '0 && remain_ff <= count_ff, "walk counter out of range")
   `DCFL_ASSERT_NEXT(a_alloc_starts_walk, alloc_go, state_ff == WALK && remain_ff <= free_total_ff, "allocate did not start a walk")
   `DCFL_ASSERT_NEXT(a_result_handed_over, state_ff == DONE && res_take, state_ff == IDLE, "result taken but sequencer busy")
   `DCFL_ASSERT_IMPL(a_idle_no_access, state_ff == IDLE || state_ff == DONE, !link_cmd.wr_en && !rec_cmd.wr_en, "store written outside a command")

endmodule

[dv/descriptor_chain_free_list_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for descriptor_chain_free_list_core: allocate and free commands
// against a free list model held in a small scoreboard class. Depends on dcfl_pkg, dcfl_if.
module descriptor_chain_free_list_core_tb;
   import dcfl_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int MAX_COUNT_CODE = (1 << CNT_W) - 1;

   typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   // Tracks the descriptor ring, the chain records and the results still owed by the block.
   class free_list_scoreboard;
      logic [IDX_W-1:0] desc_next [QUEUE_DEPTH];
      logic [IDX_W-1:0] list_head;
      int               list_free;
      int               rec_len   [QUEUE_DEPTH];
      logic [IDX_W-1:0] rec_last  [QUEUE_DEPTH];
      rsp_payload_type  awaited_results[$];
      int               mismatches;

      function new();
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            desc_next[i] = IDX_W'((i + 1) % QUEUE_DEPTH);
            rec_len[i]   = 0;
            rec_last[i]  = '0;
         end
         list_head  = '0;
         list_free  = QUEUE_DEPTH;
         mismatches = 0;
      endfunction

      function rsp_payload_type note_command(req_payload_type item);
         rsp_payload_type  res;
         logic [IDX_W-1:0] walk;
         int               count;
         res        = '0;
         res.status = STATUS_OK;
         count      = int'(item.entry_count);
         if (item.cmd == CMD_ALLOC) begin
            if (count == 0 || count > QUEUE_DEPTH) begin
               res.status = STATUS_BAD_COUNT;
            end else if (count > list_free) begin
               res.status = STATUS_SHORT;
            end else begin
               walk           = list_head;
               res.chain_head = walk;
               for (int n = 0; n < count; n++) begin
                  res.chain_tail = walk;
                  walk           = desc_next[walk];
               end
               list_head                = walk;
               list_free                = list_free - count;
               rec_len[res.chain_head]  = count;
               rec_last[res.chain_head] = res.chain_tail;
            end
         end else begin
            // The returned chain is spliced in front only when the list is not empty.
            if (list_free > 0) begin
               desc_next[rec_last[item.release_head]] = list_head;
            end
            list_free = list_free + rec_len[item.release_head];
            if (list_free > QUEUE_DEPTH) begin
               list_free = QUEUE_DEPTH;
            end
            list_head = item.release_head;
         end
         res.free_left = CNT_W'(list_free);
         awaited_results.push_back(res);
         return res;
      endfunction

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
            return;
         end
         want = awaited_results.pop_front();
         if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.chain_head != want.chain_head)
            report_mismatch($sformatf("chain_head %0d, expected %0d",
                                      got.chain_head, want.chain_head));
         if (got.chain_tail != want.chain_tail)
            report_mismatch($sformatf("chain_tail %0d, expected %0d",
                                      got.chain_tail, want.chain_tail));
         if (got.free_left != want.free_left)
            report_mismatch($sformatf("free_left %0d, expected %0d",
                                      got.free_left, want.free_left));
      endtask

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $time, what);
         end
      endtask
   endclass

   logic clock;
   logic reset;

   dcfl_req_if req_if();
   dcfl_rsp_if rsp_if();

   descriptor_chain_free_list_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   free_list_scoreboard sb;
   logic [IDX_W-1:0]    live_heads[$];
   logic [IDX_W-1:0]    written_heads[$];
   bit                  ever_written [QUEUE_DEPTH];
   int                  burst_left;
   int                  stall_cycles;
   int                  rx_seen;
   int                  rx_phase_left;
   int                  rx_hold_left;
   bit                  rx_hold_done;
   rx_mode_type         rx_mode;

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      burst_left     = 0;
      stall_cycles   = 0;
      rx_seen        = 0;
      rx_phase_left  = 0;
      rx_hold_left   = 0;
      rx_hold_done   = 1'b0;
      rx_mode        = RX_STREAM;
      sb             = new();
   end

   always #5 clock = ~clock;

   // Offers one transaction, working in bursts with random gaps, and records its outcome.
   task automatic issue(input req_payload_type item);
      rsp_payload_type outcome;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      outcome = sb.note_command(item);
      if (item.cmd == CMD_ALLOC && outcome.status == STATUS_OK) begin
         live_heads.push_back(outcome.chain_head);
         if (!ever_written[outcome.chain_head]) begin
            ever_written[outcome.chain_head] = 1'b1;
            written_heads.push_back(outcome.chain_head);
         end
      end else if (item.cmd == CMD_FREE) begin
         for (int i = 0; i < live_heads.size(); i++) begin
            if (live_heads[i] == item.release_head) begin
               live_heads.delete(i);
               break;
            end
         end
      end
   endtask

   task automatic request_alloc(input int count);
      req_payload_type item;
      item.cmd          = CMD_ALLOC;
      item.entry_count  = CNT_W'(count);
      item.release_head = IDX_W'($urandom);
      issue(item);
   endtask

   task automatic request_free(input logic [IDX_W-1:0] head);
      req_payload_type item;
      item.cmd          = CMD_FREE;
      item.entry_count  = CNT_W'($urandom);
      item.release_head = head;
      issue(item);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (sb.awaited_results.size() > 0) @(posedge clock);
   endtask

   task automatic run_directed();
      request_alloc(1);
      request_alloc(0);
      request_alloc(QUEUE_DEPTH + 1);
      request_alloc(MAX_COUNT_CODE);
      request_alloc(QUEUE_DEPTH);          // one descriptor short
      request_alloc(QUEUE_DEPTH - 1);      // takes the rest of the list
      request_alloc(1);                    // nothing left at all
      request_free(live_heads[$]);         // returned onto an empty list
      request_free(live_heads[0]);
      request_alloc(QUEUE_DEPTH);
      request_free(live_heads[$]);
      // Freeing the whole ring a second time leaves the links as they are and saturates.
      request_free(written_heads[0]);
      request_alloc(7);
      request_alloc(9);
      request_alloc(QUEUE_DEPTH - 16);
      request_alloc(1);
      request_free(live_heads[0]);
      request_alloc(8);
      request_alloc(7);
      while (live_heads.size() > 0) request_free(live_heads[$]);
   endtask

   task automatic run_random(input int total);
      req_payload_type item;
      int              pick;
      int              limit;
      int              alloc_share;
      bit              broken;
      alloc_share = 50;
      for (int n = 0; n < total; n++) begin
         if (n == total / 2) drain_results();
         if (n % 100 == 0) alloc_share = $urandom_range(35, 70);
         // A double free corrupts the ring for good, so those come only at the very end.
         broken            = (n >= total - total / 32);
         item.cmd          = CMD_ALLOC;
         item.entry_count  = CNT_W'($urandom);
         item.release_head = IDX_W'($urandom);
         pick              = $urandom_range(0, 99);
         if (pick < 4) begin
            item.entry_count = ($urandom_range(0, 1) == 0)
                               ? '0 : CNT_W'($urandom_range(QUEUE_DEPTH + 1, MAX_COUNT_CODE));
         end else if (broken && pick < 14 && written_heads.size() > 0) begin
            item.cmd          = CMD_FREE;
            item.release_head = written_heads[$urandom_range(0, written_heads.size() - 1)];
         end else if (pick < alloc_share || live_heads.size() == 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) limit = 8;
            else if (pick < 19) limit = sb.list_free + 4;
            else limit = QUEUE_DEPTH;
            if (limit > QUEUE_DEPTH) limit = QUEUE_DEPTH;
            item.entry_count = CNT_W'($urandom_range(1, limit));
         end else begin
            item.cmd          = CMD_FREE;
            item.release_head = live_heads[$urandom_range(0, live_heads.size() - 1)];
         end
         issue(item);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain_results();
      run_random(RANDOM_ITEMS);
      drain_results();
      repeat (80) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Receiver: changes its stall pattern from phase to phase and holds off once for long.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) rx_seen++;
      if (!rx_hold_done && rx_seen == 300) begin
         rx_hold_left = 500;
         rx_hold_done = 1'b1;
      end
      if (rx_phase_left == 0) begin
         rx_mode       = rx_mode_type'($urandom_range(0, 3));
         rx_phase_left = $urandom_range(20, 120);
      end
      rx_phase_left--;
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_STREAM: rsp_if.ready <= 1'b1;
            RX_HALF:   rsp_if.ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_if.ready <= rx_phase_left[0];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
